### hdl/frs_pkg.sv
// frs_pkg: shared types and constants of the Fenwick range-sum unit.
// Used by frs_front, frs_back, fenwick_range_sum_unit and frs_checker; no dependencies.
`default_nettype none

package frs_pkg;

   localparam int IDX_W       = 10;
   localparam int IN_VALUE_W  = 32;
   localparam int SUM_W       = 32;
   localparam int COUNT_W     = 11;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   // req_tdata layout
   localparam int IDX_LSB   = 0;
   localparam int VALUE_LSB = 10;
   localparam int LEFT_LSB  = 42;
   localparam int RIGHT_LSB = 52;

   localparam logic ACTION_SET   = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [1:0] {
      CMD_SET,
      CMD_QUERY,
      CMD_FAULT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [IDX_W-1:0]       index;
      logic [IN_VALUE_W-1:0]  value;
      logic [IDX_W-1:0]       left;
      logic [IDX_W-1:0]       right;
   } cmd_type;

   // head of the command queue, front to back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   // back to front
   typedef struct packed {
      logic pop;
      logic clearing;
   } backstat_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_ELEM,
      ST_SET_DELTA,
      ST_SET_WALK,
      ST_QUERY,
      ST_RESP
   } back_state_type;

endpackage

`default_nettype wire

### hdl/frs_ram.sv
// frs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module frs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/frs_front.sv
// frs_front: accepts request words, range-checks them and queues commands.
// Depends on frs_pkg.
`default_nettype none

module frs_front #(
   parameter int CNT_W = 11
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [frs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                             req_tuser,
   input  wire logic [CNT_W-1:0]                 element_limit,
   input  wire frs_pkg::backstat_type            stat,
   output frs_pkg::qhead_type                    head
);

   frs_pkg::cmd_type             entries_ff [2];
   logic                         wr_ptr_ff, wr_ptr_in;
   logic                         rd_ptr_ff, rd_ptr_in;
   logic [1:0]                   fill_ff, fill_in;
   logic                         push;
   logic                         pop;
   frs_pkg::cmd_type             new_cmd;
   logic [frs_pkg::IDX_W-1:0]    idx;
   logic [frs_pkg::IDX_W-1:0]    left;
   logic [frs_pkg::IDX_W-1:0]    right;
   logic [31:0]                  limit32;
   logic                         idx_bad;
   logic                         range_bad;

   assign idx   = req_tdata[frs_pkg::IDX_LSB +: frs_pkg::IDX_W];
   assign left  = req_tdata[frs_pkg::LEFT_LSB +: frs_pkg::IDX_W];
   assign right = req_tdata[frs_pkg::RIGHT_LSB +: frs_pkg::IDX_W];

   assign limit32   = 32'(element_limit);
   assign idx_bad   = 32'(idx) >= limit32;
   assign range_bad = (32'(left) >= limit32) || (32'(right) >= limit32);

   always_comb begin
      new_cmd.index = idx;
      new_cmd.value = req_tdata[frs_pkg::VALUE_LSB +: frs_pkg::IN_VALUE_W];
      new_cmd.left  = left;
      new_cmd.right = right;
      if (req_tuser == frs_pkg::ACTION_QUERY) begin
         new_cmd.kind = range_bad ? frs_pkg::CMD_FAULT : frs_pkg::CMD_QUERY;
      end else begin
         new_cmd.kind = idx_bad ? frs_pkg::CMD_FAULT : frs_pkg::CMD_SET;
      end
   end

   assign req_tready = !stat.clearing && (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = stat.pop;

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign fill_in   = 2'(fill_ff + 2'(push) - 2'(pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign head.valid = (fill_ff != 2'd0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### hdl/frs_back.sv
// frs_back: sequencer that walks the tree RAM for sets and queries and holds the
// result word. Depends on frs_pkg and frs_ram.
`default_nettype none

module frs_back #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int VALUE_BITS   = 32,
   parameter int CNT_W        = 11
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire frs_pkg::qhead_type               head,
   output frs_pkg::backstat_type                 stat,
   input  wire logic [CNT_W-1:0]                 element_limit,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [frs_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser
);

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int NW = CNT_W + 1;

   frs_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   frs_pkg::cmd_type        cmd_ff, cmd_in;
   logic [NW-1:0]           node_ff, node_in;
   logic [NW-1:0]           wnode_ff, wnode_in;
   logic [VALUE_BITS-1:0]   delta_ff, delta_in;
   logic [VALUE_BITS-1:0]   acc_ff, acc_in;
   logic                    pend_ff, pend_in;
   logic                    phase_ff, phase_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [frs_pkg::SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic                    tree_we, tree_re;
   logic [AW-1:0]           tree_waddr, tree_raddr;
   logic [VALUE_BITS-1:0]   tree_wdata, tree_rdata;
   logic                    elem_we, elem_re;
   logic [AW-1:0]           elem_waddr, elem_raddr;
   logic [VALUE_BITS-1:0]   elem_wdata, elem_rdata;

   logic [NW-1:0]           lowbit;
   logic [NW-1:0]           limit;
   logic                    node_in_range;
   logic                    rsp_free;
   logic                    clr_done;
   logic [63:0]             value_ext;
   logic [VALUE_BITS-1:0]   set_value;

   assign lowbit        = NW'(node_ff & NW'(~node_ff + 1'b1));
   assign limit         = NW'(element_limit);
   assign node_in_range = node_ff <= limit;
   assign rsp_free      = !rsp_valid_ff || rsp_tready;
   assign clr_done      = clr_ff == AW'(MAX_ELEMENTS - 1);
   assign value_ext     = {{32{cmd_ff.value[31]}}, cmd_ff.value};
   assign set_value     = value_ext[VALUE_BITS-1:0];

   frs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ELEMENTS)) u_tree (
      .clock   (clock),
      .wr_en   (tree_we),
      .wr_addr (tree_waddr),
      .wr_data (tree_wdata),
      .rd_en   (tree_re),
      .rd_addr (tree_raddr),
      .rd_data (tree_rdata)
   );

   frs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ELEMENTS)) u_elem (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_waddr),
      .wr_data (elem_wdata),
      .rd_en   (elem_re),
      .rd_addr (elem_raddr),
      .rd_data (elem_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         frs_pkg::ST_CLEAR: begin
            if (clr_done) state_in = frs_pkg::ST_IDLE;
         end
         frs_pkg::ST_IDLE: begin
            if (head.valid) begin
               unique case (head.cmd.kind)
                  frs_pkg::CMD_SET:   state_in = frs_pkg::ST_SET_ELEM;
                  frs_pkg::CMD_QUERY: state_in = frs_pkg::ST_QUERY;
                  default:            state_in = frs_pkg::ST_RESP;
               endcase
            end
         end
         frs_pkg::ST_SET_ELEM:  state_in = frs_pkg::ST_SET_DELTA;
         frs_pkg::ST_SET_DELTA: state_in = frs_pkg::ST_SET_WALK;
         frs_pkg::ST_SET_WALK: begin
            if (!node_in_range) state_in = frs_pkg::ST_IDLE;
         end
         frs_pkg::ST_QUERY: begin
            if (node_ff == '0 && phase_ff) state_in = frs_pkg::ST_RESP;
         end
         frs_pkg::ST_RESP: begin
            if (rsp_free) state_in = frs_pkg::ST_IDLE;
         end
         default: state_in = frs_pkg::ST_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      node_in       = node_ff;
      wnode_in      = wnode_ff;
      delta_in      = delta_ff;
      acc_in        = acc_ff;
      pend_in       = pend_ff;
      phase_in      = phase_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      stat.pop      = 1'b0;
      stat.clearing = 1'b0;
      tree_we       = 1'b0;
      tree_waddr    = AW'(wnode_ff - 1'b1);
      tree_wdata    = VALUE_BITS'(tree_rdata + delta_ff);
      tree_re       = 1'b0;
      tree_raddr    = AW'(node_ff - 1'b1);
      elem_we       = 1'b0;
      elem_waddr    = AW'(cmd_ff.index);
      elem_wdata    = set_value;
      elem_re       = 1'b0;
      elem_raddr    = AW'(cmd_ff.index);

      unique case (state_ff)
         frs_pkg::ST_CLEAR: begin
            stat.clearing = 1'b1;
            tree_we       = 1'b1;
            tree_waddr    = clr_ff;
            tree_wdata    = '0;
            elem_we       = 1'b1;
            elem_waddr    = clr_ff;
            elem_wdata    = '0;
            clr_in        = AW'(clr_ff + 1'b1);
         end
         frs_pkg::ST_IDLE: begin
            if (head.valid) begin
               stat.pop = 1'b1;
               cmd_in   = head.cmd;
               node_in  = NW'(NW'(head.cmd.right) + 1'b1);
               acc_in   = '0;
               pend_in  = 1'b0;
               phase_in = 1'b0;
            end
         end
         frs_pkg::ST_SET_ELEM: begin
            elem_re = 1'b1;
            node_in = NW'(NW'(cmd_ff.index) + 1'b1);
         end
         frs_pkg::ST_SET_DELTA: begin
            // old element arrives now; the first node is always in range
            delta_in = VALUE_BITS'(set_value - elem_rdata);
            elem_we  = 1'b1;
            tree_re  = 1'b1;
            wnode_in = node_ff;
            node_in  = NW'(node_ff + lowbit);
         end
         frs_pkg::ST_SET_WALK: begin
            // write back the node read last cycle, read the next one
            tree_we = 1'b1;
            if (node_in_range) begin
               tree_re  = 1'b1;
               wnode_in = node_ff;
               node_in  = NW'(node_ff + lowbit);
            end
         end
         frs_pkg::ST_QUERY: begin
            // phase 0 adds prefix(right+1), phase 1 subtracts prefix(left)
            if (pend_ff) begin
               acc_in = phase_ff ? VALUE_BITS'(acc_ff - tree_rdata)
                                 : VALUE_BITS'(acc_ff + tree_rdata);
            end
            if (node_ff != '0) begin
               tree_re = 1'b1;
               node_in = NW'(node_ff - lowbit);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  node_in  = NW'(cmd_ff.left);
               end
            end
         end
         frs_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (cmd_ff.kind == frs_pkg::CMD_FAULT) begin
                  rsp_sum_in    = '0;
                  rsp_status_in = frs_pkg::STATUS_RANGE;
               end else begin
                  rsp_sum_in    = frs_pkg::SUM_W'(acc_ff);
                  rsp_status_in = frs_pkg::STATUS_OK;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      node_ff       <= node_in;
      wnode_ff      <= wnode_in;
      delta_ff      <= delta_in;
      acc_ff        <= acc_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sum_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

### hdl/fenwick_range_sum_unit.sv
// fenwick_range_sum_unit: top level of the Fenwick-tree range-sum unit.
// Depends on frs_pkg, frs_front, frs_back (and frs_ram through frs_back).
//
//  channel | dir | handshake         | payload
//  req     | in  | req_tvalid/tready | tdata: index, value, left, right; tuser: action
//  rsp     | out | rsp_tvalid/tready | tdata: range_sum; tuser: status
//  csr     | in  | csr_wr_en         | csr_wr_data: element_count
//
// After reset a clearing pass zeroes both RAMs with req_tready low. A set reads the old
// element, then walks and updates the tree nodes; a query walks the right+1 prefix, then
// the left prefix; an out-of-range word goes straight to the result. The tree RAM has a
// single read port, so each walk reads one node at a time. A two-word queue sits between
// the front and the sequencer, and the result register lets work go on while rsp stalls.
`default_nettype none

module fenwick_range_sum_unit #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int VALUE_BITS   = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [9:0] element_index, [41:10] new_value, [51:42] range_left, [61:52] range_right
   input  wire logic [frs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] action
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [31:0] range_sum
   output logic      [frs_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [0] status
   output logic                                   rsp_tuser,
   input  wire logic                              csr_wr_en,
   input  wire logic [frs_pkg::COUNT_W-1:0]       csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   logic [frs_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0]            element_limit;
   frs_pkg::qhead_type          head;
   frs_pkg::backstat_type       stat;

   assign count_in = csr_wr_en ? csr_wr_data : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= frs_pkg::COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // counts above the array size act as the array size
   assign element_limit = (32'(count_ff) > 32'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                               : CNT_W'(count_ff);

   frs_front #(.CNT_W(CNT_W)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .element_limit (element_limit),
      .stat          (stat),
      .head          (head)
   );

   frs_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_BITS   (VALUE_BITS),
      .CNT_W        (CNT_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .stat          (stat),
      .element_limit (element_limit),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

`default_nettype wire

### hdl/frs_checker.sv
// frs_checker: port-level assertions for fenwick_range_sum_unit, bound to the top.
// Depends on frs_pkg.
`default_nettype none

module frs_port_asserts (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [frs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tuser
);

   // the clearing pass keeps the input closed and the output empty right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("input open or result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // an out-of-range word always reports a zero sum
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == frs_pkg::STATUS_RANGE |-> rsp_tdata == '0)
      else $error("range error with nonzero sum");

endmodule

bind fenwick_range_sum_unit frs_port_asserts u_frs_port_asserts (.*);

`default_nettype wire

### verif/frs_checker.sv
// frs_checker: watches the req, rsp and csr ports of fenwick_range_sum_unit, keeps its own
// copy of the tree and element stores, predicts each result word and compares it.
// Depends on frs_pkg.

module frs_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [frs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                              req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [frs_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire logic                              rsp_tuser,
   input  wire logic                              csr_wr_en,
   input  wire logic [frs_pkg::COUNT_W-1:0]       csr_wr_data,
   output int                                     fail_count,
   output int                                     pending,
   output int                                     checked
);
   import frs_pkg::*;

   localparam int TREE_N = 1024;

   typedef struct packed {
      logic [SUM_W-1:0] total;
      logic             status;
   } range_result_type;

   range_result_type   due_sums[$];
   logic [SUM_W-1:0]   node_sum [1:TREE_N];
   logic [SUM_W-1:0]   elem_val [0:TREE_N-1];
   logic [COUNT_W-1:0] count_reg;

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
   end

   task automatic report(string msg);
      if (fail_count < 30)
         $display("frs_checker: %s", msg);
      fail_count++;
   endtask

   // counts above the tree size act as the tree size
   function automatic int unsigned live_len();
      return (count_reg > TREE_N) ? TREE_N : int'(count_reg);
   endfunction

   function automatic logic [SUM_W-1:0] prefix_sum(int unsigned n);
      logic [SUM_W-1:0] acc;
      int unsigned k;
      acc = '0;
      k   = n;
      while (k > 0) begin
         acc += node_sum[k];
         k -= k & (~k + 1);
      end
      return acc;
   endfunction

   task automatic push_result(logic [SUM_W-1:0] total, logic status);
      range_result_type r;
      r.total  = total;
      r.status = status;
      due_sums.push_back(r);
   endtask

   task automatic apply_set(int unsigned idx, logic [SUM_W-1:0] val);
      logic [SUM_W-1:0] delta;
      int unsigned lim, k;
      lim = live_len();
      if (idx >= lim) begin
         push_result('0, STATUS_RANGE);
         return;
      end
      delta = val - elem_val[idx];
      // update walk stops at the count in force now; nodes past it go stale
      k = idx + 1;
      while (k <= lim) begin
         node_sum[k] += delta;
         k += k & (~k + 1);
      end
      elem_val[idx] = val;
   endtask

   task automatic apply_query(int unsigned left, int unsigned right);
      int unsigned lim;
      lim = live_len();
      if (left >= lim || right >= lim)
         push_result('0, STATUS_RANGE);
      else
         push_result(prefix_sum(right + 1) - prefix_sum(left), STATUS_OK);
   endtask

   always @(posedge clock) begin
      range_result_type want;
      if (reset) begin
         for (int i = 1; i <= TREE_N; i++) node_sum[i] = '0;
         for (int i = 0; i < TREE_N; i++) elem_val[i] = '0;
         count_reg = COUNT_RESET;
         due_sums.delete();
      end else begin
         // a result never leaves in the cycle its request word is taken
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (due_sums.size() == 0) begin
               report($sformatf("unexpected result word: sum %h status %b",
                                rsp_tdata, rsp_tuser));
            end else begin
               want = due_sums.pop_front();
               if (rsp_tdata !== want.total)
                  report($sformatf("result %0d range_sum: expected %h, got %h",
                                   checked, want.total, rsp_tdata));
               if (rsp_tuser !== want.status)
                  report($sformatf("result %0d status: expected %b, got %b",
                                   checked, want.status, rsp_tuser));
            end
         end
         if (csr_wr_en)
            count_reg = csr_wr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACTION_SET)
               apply_set(req_tdata[IDX_LSB +: IDX_W], req_tdata[VALUE_LSB +: IN_VALUE_W]);
            else
               apply_query(req_tdata[LEFT_LSB +: IDX_W], req_tdata[RIGHT_LSB +: IDX_W]);
         end
      end
      pending = due_sums.size();
   end

endmodule

### verif/tb_top.sv
// tb_top: stimulus and verdict for fenwick_range_sum_unit: directed sets and queries,
// then random phases over several element counts. Depends on frs_pkg and frs_checker.

module tb_top;
   import frs_pkg::*;

   localparam int SETTLE = 100;    // cycles for in-flight sets to finish
   localparam int LIMIT  = 4000;   // cycles without any handshake

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata   = '0;
   logic                     req_tuser   = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0]       csr_wr_data = '0;

   int fail_count, pending, checked;
   int words_sent    = 0;
   int counts_used   = 0;
   int cur_count     = 1024;
   int stuck_cycles  = 0;
   bit gaps_on       = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   fenwick_range_sum_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   frs_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked)
   );

   always @(posedge clock) begin
      rsp_tready <= gaps_on ? ($urandom_range(0, 99) >= 22) : 1'b1;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= LIMIT) begin
            $display("tb_top: no handshake for %0d cycles", LIMIT);
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // send_word lowers valid only in a gap, so back-to-back words keep it high
   task automatic send_word(logic act, int unsigned idx, logic [IN_VALUE_W-1:0] val,
                            int unsigned left, int unsigned right);
      logic [REQ_TDATA_W-1:0] data;
      data = '0;
      data[IDX_LSB   +: IDX_W]      = idx[IDX_W-1:0];
      data[VALUE_LSB +: IN_VALUE_W] = val;
      data[LEFT_LSB  +: IDX_W]      = left[IDX_W-1:0];
      data[RIGHT_LSB +: IDX_W]      = right[IDX_W-1:0];
      while (gaps_on && $urandom_range(0, 99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= act;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_set(int unsigned idx, logic [IN_VALUE_W-1:0] val);
      send_word(ACTION_SET, idx, val, $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   task automatic send_query(int unsigned left, int unsigned right);
      send_word(ACTION_QUERY, $urandom_range(0, 1023), $urandom(), left, right);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register is only written with the unit idle
   task automatic set_count(int unsigned value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[COUNT_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_count = value;
      counts_used++;
   endtask

   function automatic int unsigned pick_index(int unsigned live, bit in_range);
      if (in_range && live > 0)
         return $urandom_range(0, live - 1);
      if (live < 1024 && $urandom_range(0, 1))
         return $urandom_range(live, 1023);
      return $urandom_range(0, 1023);
   endfunction

   task automatic send_random();
      int unsigned live;
      bit in_range;
      logic [IN_VALUE_W-1:0] val;
      live     = (cur_count > 1024) ? 1024 : cur_count;
      in_range = $urandom_range(0, 99) < 88;
      case ($urandom_range(0, 3))
         0: val = $urandom();
         1: val = 32'($urandom_range(0, 16)) - 32'd8;
         2: val = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: val = {($urandom_range(0, 1) ? 16'hffff : 16'h0000), 16'($urandom())};
      endcase
      if ($urandom_range(0, 99) < 55)
         send_word(ACTION_SET, pick_index(live, in_range), val,
                   $urandom_range(0, 1023), $urandom_range(0, 1023));
      else
         send_word(ACTION_QUERY, $urandom_range(0, 1023), val,
                   pick_index(live, in_range || $urandom_range(0, 1)),
                   pick_index(live, in_range || $urandom_range(0, 1)));
   endtask

   initial begin
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset count: extremes of value and index, wrap, reversed ranges
      send_set(0, 32'h7fff_ffff);
      send_set(1023, 32'h8000_0000);
      send_set(511, 32'hffff_ffff);
      send_query(0, 1023);
      send_query(0, 0);
      send_query(1023, 1023);
      send_query(900, 10);
      send_set(0, 32'h7fff_ffff);     // zero delta
      send_set(0, 32'd5);
      send_query(0, 511);
      send_query(1023, 0);

      // zero count: everything out of range
      set_count(0);
      send_set(0, 32'd1);
      send_query(0, 0);

      // count above the tree size acts as the tree size
      set_count(2047);
      send_query(0, 1023);
      send_set(1023, 32'd3);
      send_query(1023, 1023);

      set_count(1);
      send_set(0, 32'd9);
      send_set(1, 32'd1);
      send_query(0, 0);
      send_query(0, 1);
      send_query(1, 0);

      // raised count without rebuild: upper nodes are stale
      set_count(1024);
      send_query(0, 1023);

      for (int ph = 0; ph < 8; ph++) begin
         n = 55;
         case (ph)
            0: set_count(1024);
            1: set_count(1);
            2: set_count($urandom_range(2, 16));
            3: set_count(1024);
            4: begin
               set_count(0);
               n = 12;
            end
            5: set_count($urandom_range(1025, 2047));
            6: set_count($urandom_range(17, 1023));
            default: set_count(1024);
         endcase
         gaps_on = (ph != 0);
         repeat (n) send_random();
      end

      drain();
      $display("tb_top: %0d request words sent under %0d element-count settings",
               words_sent, counts_used);
      $display("tb_top: %0d result words checked, %0d mismatches", checked, fail_count);
      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

### fenwick_range_sum_unit.f
hdl/frs_pkg.sv
hdl/frs_ram.sv
hdl/frs_front.sv
hdl/frs_back.sv
hdl/fenwick_range_sum_unit.sv
hdl/frs_checker.sv
verif/frs_checker.sv
verif/tb_top.sv
